/* hdl/adsr_envelope_generator_defines.svh */
`ifndef ADSR_ENVELOPE_GENERATOR_DEFINES_SVH
`define ADSR_ENVELOPE_GENERATOR_DEFINES_SVH

// condition that holds on every clock edge out of reset
`define ADSR_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define ADSR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ADSR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/adsr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package adsr_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int FRAC_BITS       = 24;
    localparam int COEF_BITS       = 24;
    localparam int AMP_W           = FRAC_BITS + 1;
    localparam int AMP_SUM_W       = AMP_W + 1;
    localparam int HOLD_W          = 20;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = AMP_W;

    localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(1) << FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_FACTOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_SAMPLES   = 3'd4;

    localparam logic [AMP_W-1:0]     RST_ATTACK_STEP    = AMP_ONE;
    localparam logic [COEF_BITS-1:0] RST_DECAY_FACTOR   = {COEF_BITS{1'b1}};
    localparam logic [AMP_W-1:0]     RST_SUSTAIN_LEVEL  = AMP_ONE >> 1;
    localparam logic [COEF_BITS-1:0] RST_RELEASE_FACTOR = {COEF_BITS{1'b1}};
    localparam logic [HOLD_W-1:0]    RST_HOLD_SAMPLES   = HOLD_W'(1);

    typedef struct packed {
        logic [AMP_W-1:0]     attack_step;
        logic [COEF_BITS-1:0] decay_factor;
        logic [AMP_W-1:0]     sustain_level;
        logic [COEF_BITS-1:0] release_factor;
        logic [HOLD_W-1:0]    hold_samples;
    } adsr_cfg_t;

    typedef struct packed {
        logic idle;
        logic done;
    } adsr_status_t;

endpackage

`default_nettype wire

/* hdl/adsr_envelope_generator.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel    direction  ports                         content
// s_axis     in         s_tvalid s_tready s_tdata     sample_in, gate on s_tuser
// m_axis     out        m_tvalid m_tready m_tdata     sample_out, level
// cfg        in         cfg_we cfg_index cfg_data     envelope registers
//
// each request is stepped through by the sequencer around the single
// multiplier, used for decay, release and output scaling in turn
// s_tready is high only while the sequencer is idle
// a finished result sits in the output register; the next request is taken meanwhile
// rst_n clears the envelope state and loads the register defaults

module adsr_envelope_generator #(
    parameter int SAMPLE_BITS = adsr_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         s_tvalid,
    output logic                                              s_tready,
    // sample_in
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]             s_tdata,
    // gate
    input  wire logic                                         s_tuser,
    output logic                                              m_tvalid,
    input  wire logic                                         m_tready,
    // sample_out, level
    output logic [((SAMPLE_BITS+adsr_pkg::AMP_W+7)/8)*8-1:0]  m_tdata,
    input  wire logic                                         cfg_we,
    input  wire logic [adsr_pkg::CFG_IDX_W-1:0]               cfg_index,
    input  wire logic [adsr_pkg::CFG_DATA_W-1:0]              cfg_data
);

    localparam int AMP_W     = adsr_pkg::AMP_W;
    localparam int COEF_BITS = adsr_pkg::COEF_BITS;
    localparam int HOLD_W    = adsr_pkg::HOLD_W;
    localparam int OUT_W     = ((SAMPLE_BITS + AMP_W + 7) / 8) * 8;

    adsr_pkg::adsr_cfg_t    cfg_reg;
    adsr_pkg::adsr_status_t status;
    logic                   start;
    logic                   out_free;
    logic [SAMPLE_BITS-1:0] sample_out;
    logic [AMP_W-1:0]       level;
    logic                   m_tvalid_reg;
    logic [OUT_W-1:0]       out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_step    <= adsr_pkg::RST_ATTACK_STEP;
            cfg_reg.decay_factor   <= adsr_pkg::RST_DECAY_FACTOR;
            cfg_reg.sustain_level  <= adsr_pkg::RST_SUSTAIN_LEVEL;
            cfg_reg.release_factor <= adsr_pkg::RST_RELEASE_FACTOR;
            cfg_reg.hold_samples   <= adsr_pkg::RST_HOLD_SAMPLES;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                adsr_pkg::REG_ATTACK_STEP:
                begin
                    cfg_reg.attack_step <= cfg_data[AMP_W-1:0];
                end
                adsr_pkg::REG_DECAY_FACTOR:
                begin
                    cfg_reg.decay_factor <= cfg_data[COEF_BITS-1:0];
                end
                adsr_pkg::REG_SUSTAIN_LEVEL:
                begin
                    cfg_reg.sustain_level <= cfg_data[AMP_W-1:0];
                end
                adsr_pkg::REG_RELEASE_FACTOR:
                begin
                    cfg_reg.release_factor <= cfg_data[COEF_BITS-1:0];
                end
                adsr_pkg::REG_HOLD_SAMPLES:
                begin
                    cfg_reg.hold_samples <= cfg_data[HOLD_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign s_tready = status.idle;
    assign start    = s_tvalid & status.idle;
    assign out_free = ~m_tvalid_reg | m_tready;

    adsr_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .sample_in  (s_tdata[SAMPLE_BITS-1:0]),
        .gate       (s_tuser),
        .cfg        (cfg_reg),
        .out_free   (out_free),
        .status     (status),
        .sample_out (sample_out),
        .level      (level)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_tvalid_reg <= status.done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.done && out_free)
        begin
            out_data_reg <= OUT_W'({level, sample_out});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* hdl/adsr_mul.sv */
`timescale 1ns / 1ps
`default_nettype none

module adsr_mul #(
    parameter int A_W = adsr_pkg::AMP_SUM_W,
    parameter int B_W = adsr_pkg::COEF_BITS
) (
    input  wire logic               clk,
    input  wire logic [A_W-1:0]     a,
    input  wire logic [B_W-1:0]     b,
    output logic      [A_W+B_W-1:0] prod
);

    logic [A_W+B_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

/* hdl/adsr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "adsr_envelope_generator_defines.svh"

module adsr_ctrl #(
    parameter int SAMPLE_BITS = adsr_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [SAMPLE_BITS-1:0]      sample_in,
    input  wire logic                        gate,
    input  wire adsr_pkg::adsr_cfg_t         cfg,
    input  wire logic                        out_free,
    output adsr_pkg::adsr_status_t           status,
    output logic      [SAMPLE_BITS-1:0]      sample_out,
    output logic      [adsr_pkg::AMP_W-1:0]  level
);

    localparam int AMP_W     = adsr_pkg::AMP_W;
    localparam int AMP_SUM_W = adsr_pkg::AMP_SUM_W;
    localparam int HOLD_W    = adsr_pkg::HOLD_W;
    localparam int COEF_BITS = adsr_pkg::COEF_BITS;
    localparam int FRAC_BITS = adsr_pkg::FRAC_BITS;
    localparam int MUL_B_W   = (SAMPLE_BITS > COEF_BITS) ? SAMPLE_BITS : COEF_BITS;
    localparam int PROD_W    = AMP_SUM_W + MUL_B_W;
    localparam int P_W       = PROD_W - FRAC_BITS;

    localparam logic [P_W-1:0] LIM_NEG = P_W'(1) << (SAMPLE_BITS - 1);
    localparam logic [P_W-1:0] LIM_POS = LIM_NEG - P_W'(1);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_ATTACK  = 4'd1;
    localparam logic [3:0] ST_DEC_MUL = 4'd2;
    localparam logic [3:0] ST_DECAY   = 4'd3;
    localparam logic [3:0] ST_HOLD    = 4'd4;
    localparam logic [3:0] ST_REL_MUL = 4'd5;
    localparam logic [3:0] ST_RELEASE = 4'd6;
    localparam logic [3:0] ST_SCALE   = 4'd7;
    localparam logic [3:0] ST_SAT     = 4'd8;
    localparam logic [3:0] ST_DONE    = 4'd9;

    logic [3:0]             state_reg, state_next;
    logic [AMP_W-1:0]       amp_reg, amp_next;
    logic                   att_reg, att_next;
    logic                   dec_reg, dec_next;
    logic                   hold_reg, hold_next;
    logic                   rel_reg, rel_next;
    logic [HOLD_W-1:0]      cnt_reg, cnt_next;
    logic [SAMPLE_BITS-1:0] last_reg, last_next;
    logic                   wr_reg, wr_next;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   gate_reg;
    logic [AMP_SUM_W-1:0]   scl_amp_reg, scl_amp_next;

    logic                   trig;
    logic                   att_on;
    logic [AMP_SUM_W-1:0]   att_sum;
    logic [AMP_W-1:0]       mul_amp;
    logic                   hold_go;
    logic [HOLD_W-1:0]      cnt_step;
    logic                   cnt_done;
    logic                   hold_rel;
    logic                   smp_neg;
    logic [SAMPLE_BITS-1:0] smp_mag;
    logic [AMP_SUM_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]     mul_b;
    logic [PROD_W-1:0]      prod;
    logic [P_W-1:0]         scl_p;
    logic [P_W-1:0]         scl_sat;
    logic [SAMPLE_BITS-1:0] scl_out;

    adsr_mul #(
        .A_W (AMP_SUM_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // attack and trigger
    assign trig    = gate_reg & ~att_reg & ~hold_reg & ~dec_reg;
    assign att_on  = att_reg | trig;
    assign att_sum = {1'b0, amp_reg} + {1'b0, cfg.attack_step};

    // amplitude times a coefficient
    assign mul_amp = prod[COEF_BITS +: AMP_W];

    // hold, sustain and gate low
    assign hold_go  = (cnt_reg < cfg.hold_samples) && hold_reg;
    assign cnt_step = hold_go ? cnt_reg + HOLD_W'(1) : cnt_reg;
    assign cnt_done = cnt_step >= cfg.hold_samples;
    assign hold_rel = cnt_done & ~gate_reg;

    // sample magnitude and saturation of the scaled result
    assign smp_neg = sample_reg[SAMPLE_BITS-1];
    assign smp_mag = smp_neg ? (~sample_reg + SAMPLE_BITS'(1)) : sample_reg;
    assign scl_p   = prod[FRAC_BITS +: P_W];

    always_comb
    begin
        if (smp_neg)
        begin
            scl_sat = (scl_p > LIM_NEG) ? LIM_NEG : scl_p;
            scl_out = SAMPLE_BITS'(0) - scl_sat[SAMPLE_BITS-1:0];
        end
        else
        begin
            scl_sat = (scl_p > LIM_POS) ? LIM_POS : scl_p;
            scl_out = scl_sat[SAMPLE_BITS-1:0];
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = {1'b0, amp_reg};
        mul_b = MUL_B_W'(cfg.decay_factor);
        case (state_reg)
            ST_REL_MUL:
            begin
                mul_b = MUL_B_W'(cfg.release_factor);
            end
            ST_SCALE:
            begin
                mul_a = scl_amp_reg;
                mul_b = MUL_B_W'(smp_mag);
            end
            default:
            begin
                mul_b = MUL_B_W'(cfg.decay_factor);
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        amp_next     = amp_reg;
        att_next     = att_reg;
        dec_next     = dec_reg;
        hold_next    = hold_reg;
        rel_next     = rel_reg;
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        wr_next      = wr_reg;
        scl_amp_next = scl_amp_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                wr_next = 1'b0;
                if (start)
                begin
                    state_next = ST_ATTACK;
                end
            end
            ST_ATTACK:
            begin
                if (trig)
                begin
                    cnt_next  = '0;
                    dec_next  = 1'b0;
                    hold_next = 1'b0;
                    rel_next  = 1'b0;
                    att_next  = 1'b1;
                end
                if (att_on)
                begin
                    rel_next     = 1'b0;
                    wr_next      = 1'b1;
                    scl_amp_next = att_sum;
                    if (att_sum >= {1'b0, adsr_pkg::AMP_ONE})
                    begin
                        amp_next   = adsr_pkg::AMP_ONE;
                        att_next   = 1'b0;
                        dec_next   = 1'b1;
                        state_next = ST_DEC_MUL;
                    end
                    else
                    begin
                        amp_next   = att_sum[AMP_W-1:0];
                        state_next = (trig ? 1'b0 : dec_reg) ? ST_DEC_MUL : ST_HOLD;
                    end
                end
                else
                begin
                    state_next = dec_reg ? ST_DEC_MUL : ST_HOLD;
                end
            end
            ST_DEC_MUL:
            begin
                state_next = ST_DECAY;
            end
            ST_DECAY:
            begin
                amp_next     = mul_amp;
                wr_next      = 1'b1;
                scl_amp_next = {1'b0, mul_amp};
                if (mul_amp <= cfg.sustain_level)
                begin
                    dec_next  = 1'b0;
                    hold_next = 1'b1;
                end
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                cnt_next = cnt_step;
                if (hold_go || (cnt_done && gate_reg))
                begin
                    wr_next      = 1'b1;
                    scl_amp_next = {1'b0, amp_reg};
                end
                if (hold_rel)
                begin
                    hold_next = 1'b0;
                    rel_next  = 1'b1;
                end
                if ((hold_rel || rel_reg) && (amp_reg != '0))
                begin
                    state_next = ST_REL_MUL;
                end
                else if (wr_reg || hold_go || (cnt_done && gate_reg))
                begin
                    state_next = ST_SCALE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_REL_MUL:
            begin
                state_next = ST_RELEASE;
            end
            ST_RELEASE:
            begin
                amp_next     = mul_amp;
                wr_next      = 1'b1;
                scl_amp_next = {1'b0, mul_amp};
                state_next   = ST_SCALE;
            end
            ST_SCALE:
            begin
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                last_next  = scl_out;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            amp_reg   <= '0;
            att_reg   <= 1'b0;
            dec_reg   <= 1'b0;
            hold_reg  <= 1'b0;
            rel_reg   <= 1'b0;
            cnt_reg   <= '0;
            last_reg  <= '0;
            wr_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            amp_reg   <= amp_next;
            att_reg   <= att_next;
            dec_reg   <= dec_next;
            hold_reg  <= hold_next;
            rel_reg   <= rel_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            wr_reg    <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sample_reg <= sample_in;
            gate_reg   <= gate;
        end
        scl_amp_reg <= scl_amp_next;
    end

    assign status.idle = (state_reg == ST_IDLE);
    assign status.done = (state_reg == ST_DONE);
    assign sample_out  = last_reg;
    assign level       = amp_reg;

    `ADSR_ASSERT_ALWAYS(a_amp_max, clk, rst_n, amp_reg <= adsr_pkg::AMP_ONE, "amplitude above one")
    `ADSR_ASSERT_ALWAYS(a_phase_excl, clk, rst_n, $onehot0({att_reg, dec_reg, hold_reg}), "phases overlap")
    `ADSR_ASSERT_IMP(a_scale_wr, clk, rst_n, state_reg == ST_SCALE, wr_reg, "scale without output write")
    `ADSR_ASSERT_NXT(a_start_attack, clk, rst_n, start, state_reg == ST_ATTACK, "request not started")

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import adsr_pkg::*;

    localparam int SMP_W       = SAMPLE_BITS_DEF;
    localparam int S_DATA_W    = ((SMP_W + 7) / 8) * 8;
    localparam int M_DATA_W    = ((SMP_W + AMP_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYC  = 12;
    localparam int LONG_STALL  = 300;
    localparam int SEG_ITEMS   = 62;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [SMP_W-1:0]     SMP_MAX    = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic [SMP_W-1:0]     SMP_MIN    = {1'b1, {(SMP_W-1){1'b0}}};
    localparam logic [COEF_BITS-1:0] COEF_MAX   = {COEF_BITS{1'b1}};
    localparam logic [HOLD_W-1:0]    HOLD_MAX   = {HOLD_W{1'b1}};

    typedef struct packed {
        logic [AMP_W-1:0] level;
        logic [SMP_W-1:0] smp_out;
    } env_result_t;

    typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] value;
        logic [SMP_W-1:0]      smp;
        logic                  gate;
        logic                  typed;
        env_result_t           want;
    } stim_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // envelope shadow state
    adsr_cfg_t         env_cfg;
    logic [AMP_W-1:0]  env_amp;
    logic              atk_on;
    logic              dec_on;
    logic              hold_on;
    logic              rel_on;
    logic [HOLD_W-1:0] hold_cnt;
    logic [SMP_W-1:0]  held_out;

    env_result_t env_results_q[$];
    stim_row_t   dir_rows[$];

    int     mismatch_count = 0;
    int     src_idle_pct   = 16;
    int     sink_idle_pct  = 49;
    int     stall_asks     = 0;
    int     stall_served   = 0;
    int     stall_left     = 0;
    longint cycle_count    = 0;

    adsr_envelope_generator #(
        .SAMPLE_BITS(SMP_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [SMP_W-1:0] apply_gain(input logic [SMP_W-1:0] raw,
                                                    input logic [AMP_W:0] amp);
        logic                   neg;
        logic [SMP_W:0]         mag;
        logic [SMP_W+AMP_W+1:0] prod;
        logic [SMP_W+AMP_W+1:0] p;
        neg  = raw[SMP_W-1];
        mag  = neg ? ({1'b0, ~raw} + 1'b1) : {1'b0, raw};
        prod = mag * amp;
        p    = prod >> FRAC_BITS;
        if (neg)
        begin
            if (p > SMP_MIN)
                p = SMP_MIN;
            return -p[SMP_W-1:0];
        end
        if (p > SMP_MAX)
            p = SMP_MAX;
        return p[SMP_W-1:0];
    endfunction

    function automatic env_result_t advance_envelope(input logic [SMP_W-1:0] smp,
                                                     input logic g);
        logic [AMP_W:0]             amp_sum;
        logic [AMP_W+COEF_BITS-1:0] prod;
        env_result_t                r;
        if (g && !atk_on && !hold_on && !dec_on)
        begin
            hold_cnt = '0;
            dec_on   = 1'b0;
            hold_on  = 1'b0;
            rel_on   = 1'b0;
            atk_on   = 1'b1;
        end
        if (atk_on)
        begin
            rel_on   = 1'b0;
            amp_sum  = env_amp + env_cfg.attack_step;
            // overshoot is scaled before the clamp
            held_out = apply_gain(smp, amp_sum);
            if (amp_sum >= AMP_ONE)
            begin
                env_amp = AMP_ONE;
                atk_on  = 1'b0;
                dec_on  = 1'b1;
            end
            else
                env_amp = amp_sum[AMP_W-1:0];
        end
        if (dec_on)
        begin
            prod     = env_amp * env_cfg.decay_factor;
            env_amp  = prod[AMP_W+COEF_BITS-1:COEF_BITS];
            held_out = apply_gain(smp, {1'b0, env_amp});
            if (env_amp <= env_cfg.sustain_level)
            begin
                dec_on  = 1'b0;
                hold_on = 1'b1;
            end
        end
        if (hold_cnt < env_cfg.hold_samples && hold_on)
        begin
            held_out = apply_gain(smp, {1'b0, env_amp});
            hold_cnt = hold_cnt + 1'b1;
        end
        if (hold_cnt >= env_cfg.hold_samples && g)
            held_out = apply_gain(smp, {1'b0, env_amp});
        if (hold_cnt >= env_cfg.hold_samples && !g)
        begin
            hold_on = 1'b0;
            rel_on  = 1'b1;
        end
        if (rel_on && env_amp != '0)
        begin
            prod     = env_amp * env_cfg.release_factor;
            env_amp  = prod[AMP_W+COEF_BITS-1:COEF_BITS];
            held_out = apply_gain(smp, {1'b0, env_amp});
        end
        r.smp_out = held_out;
        r.level   = env_amp;
        return r;
    endfunction

    function automatic stim_row_t smp_row(input logic [SMP_W-1:0] smp, input logic g);
        stim_row_t r;
        r      = '0;
        r.kind = ROW_SAMPLE;
        r.smp  = smp;
        r.gate = g;
        return r;
    endfunction

    function automatic stim_row_t chk_row(input logic [SMP_W-1:0] smp, input logic g,
                                          input logic [SMP_W-1:0] want_out,
                                          input logic [AMP_W-1:0] want_level);
        stim_row_t r;
        r              = smp_row(smp, g);
        r.typed        = 1'b1;
        r.want.smp_out = want_out;
        r.want.level   = want_level;
        return r;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] value);
        stim_row_t r;
        r       = '0;
        r.kind  = ROW_REG;
        r.idx   = idx;
        r.value = value;
        return r;
    endfunction

    task automatic push_sample(input logic [SMP_W-1:0] smp, input logic g,
                               input logic typed, input env_result_t want);
        int          gap;
        env_result_t r;
        gap = ($urandom_range(99) < src_idle_pct) ? $urandom_range(1, 5) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(smp);
        s_tuser  <= g;
        do @(posedge clk); while (!s_tready);
        r = advance_envelope(smp, g);
        env_results_q.push_back(typed ? want : r);
    endtask

    task automatic settle_pipeline();
        s_tvalid <= 1'b0;
        while (env_results_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_ATTACK_STEP:    env_cfg.attack_step    = value[AMP_W-1:0];
            REG_DECAY_FACTOR:   env_cfg.decay_factor   = value[COEF_BITS-1:0];
            REG_SUSTAIN_LEVEL:  env_cfg.sustain_level  = value[AMP_W-1:0];
            REG_RELEASE_FACTOR: env_cfg.release_factor = value[COEF_BITS-1:0];
            REG_HOLD_SAMPLES:   env_cfg.hold_samples   = value[HOLD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic pick_envelope();
        logic [CFG_DATA_W-1:0] atk;
        logic [CFG_DATA_W-1:0] dcy;
        logic [CFG_DATA_W-1:0] sus;
        logic [CFG_DATA_W-1:0] rls;
        logic [CFG_DATA_W-1:0] hld;
        case ($urandom_range(9))
            0:       atk = AMP_ONE;
            1:       atk = $urandom_range(0, AMP_ONE);
            default: atk = AMP_ONE / $urandom_range(1, 12);
        endcase
        case ($urandom_range(9))
            0:       dcy = COEF_MAX;
            1:       dcy = '0;
            default: dcy = $urandom_range(24'h400000, 24'hF00000);
        endcase
        case ($urandom_range(9))
            0:       sus = AMP_ONE;
            1:       sus = '0;
            default: sus = $urandom_range(24'h200000, 24'hE00000);
        endcase
        case ($urandom_range(9))
            0:       rls = COEF_MAX;
            1:       rls = '0;
            default: rls = $urandom_range(24'h400000, 24'hF80000);
        endcase
        case ($urandom_range(9))
            0:       hld = HOLD_MAX;
            default: hld = $urandom_range(0, 6);
        endcase
        write_reg(REG_ATTACK_STEP, atk);
        write_reg(REG_DECAY_FACTOR, dcy);
        write_reg(REG_SUSTAIN_LEVEL, sus);
        write_reg(REG_RELEASE_FACTOR, rls);
        write_reg(REG_HOLD_SAMPLES, hld);
        cfg_we <= 1'b0;
    endtask

    // key presses of random length, with some gate noise
    task automatic play_notes(input int n);
        int               run;
        logic             g;
        logic [SMP_W-1:0] smp;
        g   = 1'b1;
        run = $urandom_range(1, 25);
        for (int k = 0; k < n; k++)
        begin
            if (run == 0)
            begin
                g   = ~g;
                run = g ? $urandom_range(1, 25) : $urandom_range(1, 15);
            end
            run--;
            case ($urandom_range(9))
                0:       smp = SMP_MAX;
                1:       smp = SMP_MIN;
                default: smp = SMP_W'($urandom);
            endcase
            push_sample(smp, ($urandom_range(99) < 12) ? ~g : g, 1'b0, '0);
        end
    endtask

    task automatic check_result(input logic [M_DATA_W-1:0] word);
        env_result_t want;
        env_result_t got;
        got.smp_out = word[SMP_W-1:0];
        got.level   = word[SMP_W +: AMP_W];
        if (env_results_q.size() == 0)
        begin
            $display("%0t: result with no request pending: sample_out %h level %h",
                     $time, got.smp_out, got.level);
            mismatch_count++;
        end
        else
        begin
            want = env_results_q.pop_front();
            if (got.smp_out !== want.smp_out)
            begin
                $display("%0t: sample_out mismatch: expected %h, actual %h",
                         $time, want.smp_out, got.smp_out);
                mismatch_count++;
            end
            if (got.level !== want.level)
            begin
                $display("%0t: level mismatch: expected %h, actual %h",
                         $time, want.level, got.level);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (stall_left > 0)
            begin
                m_tready   <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (stall_served != stall_asks)
            begin
                stall_served <= stall_asks;
                stall_left   <= LONG_STALL;
                m_tready     <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("adsr_envelope_generator regression: fail");
            $finish;
        end
    end

    initial
    begin
        env_cfg.attack_step    = RST_ATTACK_STEP;
        env_cfg.decay_factor   = RST_DECAY_FACTOR;
        env_cfg.sustain_level  = RST_SUSTAIN_LEVEL;
        env_cfg.release_factor = RST_RELEASE_FACTOR;
        env_cfg.hold_samples   = RST_HOLD_SAMPLES;
        env_amp  = '0;
        atk_on   = 1'b0;
        dec_on   = 1'b0;
        hold_on  = 1'b0;
        rel_on   = 1'b0;
        hold_cnt = '0;
        held_out = '0;

        // idle after reset: nothing active, output and level stay zero
        dir_rows.push_back(chk_row('0, 1'b0, '0, '0));
        dir_rows.push_back(chk_row(SMP_MAX, 1'b0, '0, '0));
        dir_rows.push_back(smp_row(SMP_MAX, 1'b1));
        dir_rows.push_back(smp_row(SMP_MIN, 1'b1));
        // full walk through decay, hold, sustain, release, retrigger
        dir_rows.push_back(reg_row(REG_ATTACK_STEP, AMP_ONE >> 1));
        dir_rows.push_back(reg_row(REG_DECAY_FACTOR, 24'h800000));
        dir_rows.push_back(reg_row(REG_SUSTAIN_LEVEL, AMP_ONE >> 2));
        dir_rows.push_back(reg_row(REG_RELEASE_FACTOR, 24'h800000));
        dir_rows.push_back(reg_row(REG_HOLD_SAMPLES, 2));
        dir_rows.push_back(smp_row(SMP_MIN, 1'b1));
        dir_rows.push_back(smp_row(1, 1'b1));
        dir_rows.push_back(smp_row('1, 1'b1));
        dir_rows.push_back(smp_row(SMP_MAX, 1'b1));
        dir_rows.push_back(smp_row(SMP_MAX, 1'b0));
        dir_rows.push_back(smp_row(SMP_MIN, 1'b0));
        dir_rows.push_back(smp_row(SMP_MAX, 1'b1));
        // attack overshoot, zero hold length
        dir_rows.push_back(reg_row(REG_ATTACK_STEP, AMP_ONE));
        dir_rows.push_back(reg_row(REG_HOLD_SAMPLES, 0));
        dir_rows.push_back(reg_row(REG_DECAY_FACTOR, COEF_MAX));
        dir_rows.push_back(reg_row(REG_SUSTAIN_LEVEL, AMP_ONE));
        dir_rows.push_back(smp_row(SMP_MAX, 1'b1));
        dir_rows.push_back(smp_row(SMP_MIN, 1'b1));
        dir_rows.push_back(smp_row(1, 1'b0));
        dir_rows.push_back(smp_row(SMP_MIN, 1'b1));
        // longest hold, then hold length lowered below the count
        dir_rows.push_back(reg_row(REG_HOLD_SAMPLES, HOLD_MAX));
        dir_rows.push_back(reg_row(REG_ATTACK_STEP, 0));
        dir_rows.push_back(reg_row(REG_DECAY_FACTOR, 0));
        dir_rows.push_back(reg_row(REG_SUSTAIN_LEVEL, 0));
        dir_rows.push_back(reg_row(REG_RELEASE_FACTOR, 0));
        dir_rows.push_back(smp_row(24'h5A5A5A, 1'b1));
        dir_rows.push_back(smp_row(24'hA5A5A5, 1'b0));
        dir_rows.push_back(reg_row(REG_HOLD_SAMPLES, 1));
        dir_rows.push_back(smp_row(SMP_MAX, 1'b1));
        dir_rows.push_back(smp_row(SMP_MIN, 1'b0));
        dir_rows.push_back(smp_row(SMP_MAX, 1'b0));
        dir_rows.push_back(smp_row(SMP_MAX, 1'b1));
        // write outside the register map is dropped
        dir_rows.push_back(reg_row(REG_UNUSED, '1));
        dir_rows.push_back(reg_row(REG_ATTACK_STEP, 1));
        dir_rows.push_back(reg_row(REG_RELEASE_FACTOR, COEF_MAX));
        dir_rows.push_back(smp_row(SMP_MIN, 1'b1));
        dir_rows.push_back(smp_row(1, 1'b0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_REG)
            begin
                settle_pipeline();
                write_reg(dir_rows[i].idx, dir_rows[i].value);
                cfg_we <= 1'b0;
            end
            else
                push_sample(dir_rows[i].smp, dir_rows[i].gate, dir_rows[i].typed,
                            dir_rows[i].want);
        end

        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    src_idle_pct  = 16;
                    sink_idle_pct = 49;
                end
                1:
                begin
                    src_idle_pct  = 49;
                    sink_idle_pct = 16;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 3; seg++)
            begin
                settle_pipeline();
                pick_envelope();
                // receiver backs off while samples keep coming
                if (mode == 1 && seg == 1)
                    stall_asks++;
                play_notes(SEG_ITEMS);
            end
        end

        settle_pipeline();
        if (mismatch_count == 0)
            $display("adsr_envelope_generator regression: pass");
        else
            $display("adsr_envelope_generator regression: fail");
        $finish;
    end

endmodule

/* adsr_envelope_generator.f */
+incdir+hdl
hdl/adsr_pkg.sv
hdl/adsr_mul.sv
hdl/adsr_ctrl.sv
hdl/adsr_envelope_generator.sv
tb/sv/tb_top.sv
